// ===== hdl/jkve_pkg.sv =====
package jkve_pkg;

  localparam int unsigned PATTERN_MAX = 16;
  localparam int unsigned WIN_IDX_W   = $clog2(PATTERN_MAX);
  localparam int unsigned FILL_W      = $clog2(PATTERN_MAX + 1);

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_VALUE_MODE     = CFG_IDX_W'(3);

  localparam logic [7:0] CHAR_COMMA       = 8'h2C;
  localparam logic [7:0] CHAR_CLOSE_BRACE = 8'h7D;
  localparam logic [7:0] CHAR_UPPER_A     = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z     = 8'h5A;
  localparam logic [7:0] CASE_OFFSET      = 8'h20;

  localparam logic MODE_RAW    = 1'b0;
  localparam logic MODE_STRING = 1'b1;

  // control from the capture logic to the key window
  typedef struct packed {
    logic shift;
    logic clear;
  } win_ctrl_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       value_done;
  } result_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      r = c + CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

// ===== hdl/jkve_window.sv =====
module jkve_window (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  jkve_pkg::win_ctrl_t        ctrl_i,
  input  logic [7:0]                 byte_i,
  input  logic [63:0]                pattern_low_i,
  input  logic [63:0]                pattern_high_i,
  input  logic [4:0]                 pattern_length_i,
  output logic                       match_o
);
  import jkve_pkg::*;

  logic [7:0]        window_q [PATTERN_MAX];
  logic [7:0]        window_d [PATTERN_MAX];
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [FILL_W-1:0] len_eff;
  logic [127:0]      pattern;
  logic [PATTERN_MAX-1:0] byte_ok;

  assign pattern = {pattern_high_i, pattern_low_i};

  // lengths above the window size act as the full window
  assign len_eff = (pattern_length_i > 5'(PATTERN_MAX)) ? FILL_W'(PATTERN_MAX)
                                                         : FILL_W'(pattern_length_i);

  // window after taking the new byte, newest at the top, stored folded
  always_comb begin
    for (int j = 0; j < PATTERN_MAX - 1; j++) begin
      window_d[j] = window_q[j+1];
    end
    window_d[PATTERN_MAX-1] = fold_case(byte_i);
  end

  always_comb begin
    fill_d = fill_q;
    if (fill_q != FILL_W'(PATTERN_MAX)) begin
      fill_d = fill_q + FILL_W'(1);
    end
  end

  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cmp
    logic [FILL_W:0]    idx_wide;
    logic [WIN_IDX_W-1:0] idx;
    assign idx_wide = (FILL_W+1)'(PATTERN_MAX) - {1'b0, len_eff} + (FILL_W+1)'(i);
    assign idx      = idx_wide[WIN_IDX_W-1:0];
    assign byte_ok[i] = (FILL_W'(i) >= len_eff) ||
                        (window_d[idx] == fold_case(pattern[8*i +: 8]));
  end

  assign match_o = (len_eff != '0) && (fill_d >= len_eff) && (&byte_ok);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      window_q <= window_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (ctrl_i.clear) begin
      fill_q <= '0;
    end else if (ctrl_i.shift) begin
      fill_q <= fill_d;
    end
  end

endmodule

// ===== hdl/json_key_value_extractor_top.sv =====
// json key/value extractor
// in channel (in_valid_i/in_ready_o/in_byte_i): one character of the json
// text per item. out channel (out_valid_o/out_ready_i): one result item with
// out_byte_o, byte_valid_o and value_done_o. cfg channel: register index and
// 64-bit data; registers are pattern low, pattern high, pattern length and
// value mode, indexes beyond these are ignored. cfg_ready_o is always high.
// while searching, the last bytes are held in a 16-byte window and compared,
// case folded, with the key pattern; the byte completing a match starts the
// capture of the value up to the next comma or closing brace, which gives an
// item with value_done_o set. searching bytes and dropped quote bytes give no
// result item.
// one input item per cycle; a result is registered and appears the cycle
// after its input item is taken while the output register is free. the output
// register plus a one-entry skid stage take one more result item while the
// receiver stalls; bytes that give no result still flow, and in_ready_o drops
// only when the skid stage is full.
// reset clears the registers to zero, empties the window and both output
// stages, and returns the block to searching.
module json_key_value_extractor_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [7:0]                     in_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [7:0]                     out_byte_o,
  output logic                           byte_valid_o,
  output logic                           value_done_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [jkve_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [jkve_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import jkve_pkg::*;

  logic [63:0] pattern_low_q;
  logic [63:0] pattern_high_q;
  logic [4:0]  pattern_length_q;
  logic        value_mode_q;

  logic        capturing_q, capturing_d;
  logic        skip_first_q, skip_first_d;
  logic [7:0]  held_byte_q, held_byte_d;
  logic        held_valid_q, held_valid_d;

  result_t     out_q, skid_q, res;
  logic        out_valid_q, skid_valid_q;
  logic        res_valid;

  logic        in_acc, pop, match, delim;
  win_ctrl_t   win_ctrl;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !skid_valid_q;
  assign in_acc      = in_valid_i && in_ready_o;
  assign pop         = out_valid_q && out_ready_i;
  assign delim       = (in_byte_i == CHAR_COMMA) || (in_byte_i == CHAR_CLOSE_BRACE);

  assign win_ctrl.shift = in_acc && !capturing_q;
  assign win_ctrl.clear = in_acc && (capturing_q ? delim : match);

  jkve_window u_window (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (win_ctrl),
    .byte_i           (in_byte_i),
    .pattern_low_i    (pattern_low_q),
    .pattern_high_i   (pattern_high_q),
    .pattern_length_i (pattern_length_q),
    .match_o          (match)
  );

  always_comb begin
    capturing_d  = capturing_q;
    skip_first_d = skip_first_q;
    held_byte_d  = held_byte_q;
    held_valid_d = held_valid_q;
    res          = '0;
    res_valid    = 1'b0;
    if (in_acc) begin
      if (!capturing_q) begin
        if (match) begin
          capturing_d  = 1'b1;
          skip_first_d = 1'b1;
          held_valid_d = 1'b0;
          held_byte_d  = '0;
        end
      end else if (delim) begin
        capturing_d    = 1'b0;
        skip_first_d   = 1'b0;
        held_valid_d   = 1'b0;
        held_byte_d    = '0;
        res.value_done = 1'b1;
        res_valid      = 1'b1;
      end else if (value_mode_q == MODE_RAW) begin
        skip_first_d   = 1'b0;
        held_valid_d   = 1'b0;
        res.out_byte   = in_byte_i;
        res.byte_valid = 1'b1;
        res_valid      = 1'b1;
      end else if (skip_first_q) begin
        // opening quote
        skip_first_d = 1'b0;
      end else if (held_valid_q) begin
        // hold one byte back so the closing quote is never sent
        held_byte_d    = in_byte_i;
        res.out_byte   = held_byte_q;
        res.byte_valid = 1'b1;
        res_valid      = 1'b1;
      end else begin
        held_byte_d  = in_byte_i;
        held_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_low_q    <= '0;
      pattern_high_q   <= '0;
      pattern_length_q <= '0;
      value_mode_q     <= MODE_RAW;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_PATTERN_LOW:    pattern_low_q    <= cfg_data_i;
        REG_PATTERN_HIGH:   pattern_high_q   <= cfg_data_i;
        REG_PATTERN_LENGTH: pattern_length_q <= cfg_data_i[4:0];
        REG_VALUE_MODE:     value_mode_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capturing_q  <= 1'b0;
      skip_first_q <= 1'b0;
      held_byte_q  <= '0;
      held_valid_q <= 1'b0;
    end else begin
      capturing_q  <= capturing_d;
      skip_first_q <= skip_first_d;
      held_byte_q  <= held_byte_d;
      held_valid_q <= held_valid_d;
    end
  end

  // output register with a skid stage behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
      out_q        <= '0;
      skid_q       <= '0;
    end else if (skid_valid_q) begin
      if (pop) begin
        out_q        <= skid_q;
        skid_valid_q <= 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid_q || pop) begin
        out_q       <= res;
        out_valid_q <= 1'b1;
      end else begin
        skid_q       <= res;
        skid_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_q.out_byte;
  assign byte_valid_o = out_q.byte_valid;
  assign value_done_o = out_q.value_done;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage holds an item while the output register is empty");

  a_done_has_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(byte_valid_o && value_done_o))
    else $error("end of value item also marks a value byte");

  a_delim_ends_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && capturing_q && delim) |=> (!capturing_q && out_valid_q))
    else $error("delimiter did not end the value");

  a_held_only_in_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_valid_q || skip_first_q) |-> capturing_q)
    else $error("string state set while searching");

endmodule

// ===== verif/value_extract_checker.sv =====
module value_extract_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic [7:0]                      in_byte_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic [7:0]                      out_byte_i,
  input  logic                            byte_valid_i,
  input  logic                            value_done_i,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [jkve_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [jkve_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned                     mismatch_count_o,
  output int unsigned                     pending_values_o
);
  import jkve_pkg::*;

  localparam int unsigned MAX_REPORTED = 10;

  // shadow registers
  logic [63:0] key_lo;
  logic [63:0] key_hi;
  logic [4:0]  key_span_reg;
  logic        string_mode;

  // shadow of the search and capture state
  logic [7:0]  win_bytes [PATTERN_MAX];
  logic [4:0]  win_count;
  logic        in_value;
  logic        drop_open_quote;
  logic [7:0]  delayed_byte;
  logic        delayed_full;

  result_t     value_items_q [$];
  result_t     want;
  int unsigned mismatches;
  int unsigned values_seen;

  function automatic logic [7:0] lower_char(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      r = c | CASE_OFFSET;
    end
    return r;
  endfunction

  task automatic empty_window();
    int i;
    for (i = 0; i < PATTERN_MAX; i++) begin
      win_bytes[i] = 8'h00;
    end
    win_count = '0;
  endtask

  // works out the result item, if any, that one text byte causes
  task automatic extract_byte(input logic [7:0] b);
    int unsigned span;
    int unsigned i;
    logic [63:0] word;
    logic        hit;
    if (!in_value) begin
      for (i = 0; i < PATTERN_MAX - 1; i++) begin
        win_bytes[i] = win_bytes[i + 1];
      end
      win_bytes[PATTERN_MAX - 1] = b;
      if (win_count < PATTERN_MAX) begin
        win_count = win_count + 1'b1;
      end
      // lengths past the window size use the whole window
      span = (key_span_reg > PATTERN_MAX) ? PATTERN_MAX : key_span_reg;
      hit  = (span != 0) && (win_count >= span);
      for (i = 0; i < span; i++) begin
        word = (i < 8) ? key_lo : key_hi;
        if (lower_char(win_bytes[PATTERN_MAX - span + i]) != lower_char(word[8*(i%8) +: 8]))
        begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        in_value        = 1'b1;
        drop_open_quote = 1'b1;
        delayed_full    = 1'b0;
        delayed_byte    = 8'h00;
        empty_window();
      end
    end else if (b == CHAR_COMMA || b == CHAR_CLOSE_BRACE) begin
      in_value        = 1'b0;
      drop_open_quote = 1'b0;
      delayed_full    = 1'b0;
      delayed_byte    = 8'h00;
      empty_window();
      value_items_q.push_back(result_t'{8'h00, 1'b0, 1'b1});
    end else if (string_mode == MODE_RAW) begin
      drop_open_quote = 1'b0;
      delayed_full    = 1'b0;
      value_items_q.push_back(result_t'{b, 1'b1, 1'b0});
    end else if (drop_open_quote) begin
      drop_open_quote = 1'b0;
    end else if (delayed_full) begin
      // one byte behind so that the closing quote is never passed on
      value_items_q.push_back(result_t'{delayed_byte, 1'b1, 1'b0});
      delayed_byte = b;
    end else begin
      delayed_byte = b;
      delayed_full = 1'b1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_lo          = '0;
      key_hi          = '0;
      key_span_reg    = '0;
      string_mode     = MODE_RAW;
      in_value        = 1'b0;
      drop_open_quote = 1'b0;
      delayed_byte    = 8'h00;
      delayed_full    = 1'b0;
      empty_window();
      value_items_q.delete();
      mismatches  = 0;
      values_seen = 0;
      mismatch_count_o <= 0;
      pending_values_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_PATTERN_LOW:    key_lo = cfg_data_i;
          REG_PATTERN_HIGH:   key_hi = cfg_data_i;
          REG_PATTERN_LENGTH: key_span_reg = cfg_data_i[4:0];
          REG_VALUE_MODE:     string_mode = cfg_data_i[0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        values_seen++;
        if (value_items_q.size() == 0) begin
          if (mismatches < MAX_REPORTED) begin
            $display("value item %0d: none expected, got byte %h valid %b done %b",
                     values_seen, out_byte_i, byte_valid_i, value_done_i);
          end
          mismatches++;
        end else begin
          want = value_items_q.pop_front();
          if (want.out_byte !== out_byte_i || want.byte_valid !== byte_valid_i ||
              want.value_done !== value_done_i) begin
            if (mismatches < MAX_REPORTED) begin
              $display("value item %0d: expected %h/%b/%b, got %h/%b/%b",
                       values_seen, want.out_byte, want.byte_valid, want.value_done,
                       out_byte_i, byte_valid_i, value_done_i);
            end
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        extract_byte(in_byte_i);
      end
      mismatch_count_o <= mismatches;
      pending_values_o <= value_items_q.size();
    end
  end

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
  import jkve_pkg::*;

  localparam int unsigned RANDOM_ITEMS   = 1050;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  localparam logic [7:0] CHAR_QUOTE      = 8'h22;
  localparam logic [7:0] CHAR_COLON      = 8'h3A;
  localparam logic [7:0] CHAR_OPEN_BRACE = 8'h7B;
  localparam logic [7:0] CHAR_SPACE      = 8'h20;
  localparam logic [7:0] CHAR_LOWER_A    = 8'h61;
  localparam logic [7:0] CHAR_DIGIT_0    = 8'h30;

  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  in_valid   = 1'b0;
  logic [7:0]            in_byte    = 8'h00;
  logic                  out_ready  = 1'b0;
  logic                  cfg_valid  = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;
  logic                  calm       = 1'b0;
  int unsigned           stall_left = 0;
  int unsigned           quiet_cycles = 0;

  logic                  in_ready_o;
  logic                  out_valid_o;
  logic [7:0]            out_byte_o;
  logic                  byte_valid_o;
  logic                  value_done_o;
  logic                  cfg_ready_o;
  int unsigned           mismatches;
  int unsigned           pending_values;

  logic [7:0]  key_b [PATTERN_MAX];
  int unsigned key_bytes;
  int unsigned items_sent;

  always #4 clk_i = ~clk_i;

  json_key_value_extractor_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready_o),
    .in_byte_i    (in_byte),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready),
    .out_byte_o   (out_byte_o),
    .byte_valid_o (byte_valid_o),
    .value_done_o (value_done_o),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  value_extract_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready_o),
    .in_byte_i        (in_byte),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready),
    .out_byte_i       (out_byte_o),
    .byte_valid_i     (byte_valid_o),
    .value_done_i     (value_done_o),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatches),
    .pending_values_o (pending_values)
  );

  // mostly short gaps, now and then a long one
  function automatic int unsigned gap_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk_i) begin
    if (calm) begin
      out_ready <= 1'b1;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 2) == 0) begin
        stall_left <= gap_length();
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready_o) || (out_valid_o && out_ready) ||
        (cfg_valid && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = calm ? 0 : gap_length();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  // leaves cfg_valid high so that back-to-back writes need no second assignment
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // wait until every result item is back and the pipe has gone quiet
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_values != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_key(input logic [4:0] span, input logic mode);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] word;
    int i;
    for (i = 0; i < 8; i++) begin
      lo[8*i +: 8] = key_b[i];
      hi[8*i +: 8] = key_b[i + 8];
    end
    write_reg(REG_PATTERN_LOW, lo);
    write_reg(REG_PATTERN_HIGH, hi);
    // junk above the field width must be masked off
    word = {$urandom(), $urandom()};
    word[4:0] = span;
    write_reg(REG_PATTERN_LENGTH, word);
    word = {$urandom(), $urandom()};
    word[0] = mode;
    write_reg(REG_VALUE_MODE, word);
    // indexes past the last register are dropped
    write_reg(CFG_IDX_W'($urandom_range(REG_VALUE_MODE + 1, (1 << CFG_IDX_W) - 1)),
              {$urandom(), $urandom()});
    cfg_valid <= 1'b0;
  endtask

  // key bytes with letters flipped in case at random
  task automatic send_key_prefix(input int unsigned n);
    logic [7:0] c;
    int unsigned i;
    for (i = 0; i < n; i++) begin
      c = key_b[i];
      if ((c | CASE_OFFSET) >= CHAR_LOWER_A && (c | CASE_OFFSET) < CHAR_LOWER_A + 26 &&
          $urandom_range(0, 1) == 1) begin
        c = c ^ CASE_OFFSET;
      end
      send_byte(c);
    end
  endtask

  task automatic send_noise(input int unsigned n);
    logic [7:0] punct [6];
    int unsigned i;
    punct = '{CHAR_OPEN_BRACE, CHAR_SPACE, CHAR_QUOTE, CHAR_COLON, CHAR_COMMA, CHAR_CLOSE_BRACE};
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 4) begin
        send_byte(punct[$urandom_range(0, 5)]);
      end else begin
        send_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic run_phase(input int unsigned phase);
    logic [4:0]  span;
    logic        mode;
    logic        quoted;
    logic [7:0]  c;
    int unsigned name_len;
    int unsigned records;
    int unsigned vlen;
    int unsigned r;
    int unsigned i;
    name_len = ($urandom_range(0, 5) == 0) ? 13 : $urandom_range(1, 12);
    key_b[0] = CHAR_QUOTE;
    for (i = 1; i <= name_len; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        key_b[i] = CHAR_DIGIT_0 + 8'($urandom_range(0, 9));
      end else begin
        key_b[i] = CHAR_LOWER_A + 8'($urandom_range(0, 25));
        if ($urandom_range(0, 2) == 0) key_b[i] = key_b[i] ^ CASE_OFFSET;
      end
    end
    key_b[name_len + 1] = CHAR_QUOTE;
    key_b[name_len + 2] = CHAR_COLON;
    for (i = name_len + 3; i < PATTERN_MAX; i++) begin
      key_b[i] = 8'($urandom_range(0, 255));
    end
    key_bytes = name_len + 3;
    mode = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0:       span = 5'd0;
      1:       span = 5'($urandom_range(1, key_bytes));
      default: span = 5'(key_bytes);
    endcase
    // full-width lengths go past the window size
    if (key_bytes == PATTERN_MAX && $urandom_range(0, 1) == 1) begin
      span = 5'($urandom_range(PATTERN_MAX + 1, 31));
    end
    if (phase == 0) begin
      for (i = 0; i < PATTERN_MAX; i++) key_b[i] = 8'hFF;
      key_bytes = PATTERN_MAX;
      span = 5'd31;
    end else if (phase == 1) begin
      for (i = 0; i < PATTERN_MAX; i++) key_b[i] = 8'h00;
      span = 5'd0;
    end
    calm <= ($urandom_range(0, 3) == 0);
    program_key(span, mode);

    records = $urandom_range(3, 9);
    for (r = 0; r < records; r++) begin
      send_noise($urandom_range(0, 5));
      if ($urandom_range(0, 5) == 0) begin
        send_key_prefix($urandom_range(1, key_bytes - 1));
        send_noise($urandom_range(1, 4));
      end else begin
        send_key_prefix(key_bytes);
        vlen = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
        quoted = (mode == MODE_STRING) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 5) == 0);
        for (i = 0; i < vlen; i++) begin
          if (quoted && (i == 0 || i == vlen - 1)) begin
            c = CHAR_QUOTE;
          end else begin
            do begin
              c = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(32, 126))
                                             : 8'($urandom_range(0, 255));
            end while (c == CHAR_COMMA || c == CHAR_CLOSE_BRACE);
          end
          send_byte(c);
        end
        // the last record may stop mid-value and run on into the next setting
        if (r != records - 1 || $urandom_range(0, 4) != 0) begin
          send_byte(($urandom_range(0, 1) == 1) ? CHAR_COMMA : CHAR_CLOSE_BRACE);
        end
      end
    end
    drain();
  endtask

  initial begin
    logic [7:0]  upper_key_text [$];
    logic [7:0]  short_value_text [$];
    logic [7:0]  open_value_text [$];
    int unsigned phase;
    int i;
    upper_key_text   = '{CHAR_QUOTE, CHAR_UPPER_A, CHAR_QUOTE, CHAR_COLON,
                         CHAR_QUOTE, "x", CHAR_QUOTE, CHAR_CLOSE_BRACE};
    short_value_text = '{CHAR_QUOTE, CHAR_LOWER_A, CHAR_QUOTE, CHAR_COLON, "z", CHAR_COMMA};
    open_value_text  = '{CHAR_QUOTE, CHAR_LOWER_A, CHAR_QUOTE, CHAR_COLON, CHAR_QUOTE};
    items_sent = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // key "a" in string mode
    for (i = 0; i < PATTERN_MAX; i++) key_b[i] = 8'h00;
    key_b[0] = CHAR_QUOTE;
    key_b[1] = CHAR_LOWER_A;
    key_b[2] = CHAR_QUOTE;
    key_b[3] = CHAR_COLON;
    program_key(5'd4, MODE_STRING);
    // upper-case key in the text, quoted value closed by a brace
    foreach (upper_key_text[k]) send_byte(upper_key_text[k]);
    // one-byte value comes out empty
    foreach (short_value_text[k]) send_byte(short_value_text[k]);
    // switch to raw mode inside a value, extremes of the byte range
    foreach (open_value_text[k]) send_byte(open_value_text[k]);
    drain();
    write_reg(REG_VALUE_MODE, CFG_DATA_W'(MODE_RAW));
    cfg_valid <= 1'b0;
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CHAR_COMMA);
    drain();

    items_sent = 0;
    phase = 0;
    while (items_sent < RANDOM_ITEMS) begin
      run_phase(phase);
      phase++;
    end

    drain();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/jkve_pkg.sv
hdl/jkve_window.sv
hdl/json_key_value_extractor_top.sv
verif/value_extract_checker.sv
verif/tb_top.sv
